// ===== hdl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared widths, operation codes, compare codes and sequencer states for the
// rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    // operand and result widths
    localparam int OPERAND_WIDTH = 16;
    localparam int DEN_WIDTH     = OPERAND_WIDTH - 1;
    localparam int FUNC_WIDTH    = 3;
    localparam int ORDER_WIDTH   = 2;
    localparam int RES_NUM_WIDTH = 32;
    localparam int RES_DEN_WIDTH = 31;

    // internal widths: signed product of two (OPERAND_WIDTH+1)-bit factors,
    // and the magnitude of any numerator or denominator before reduction
    localparam int PROD_WIDTH = 2 * OPERAND_WIDTH + 2;
    localparam int MAG_WIDTH  = 2 * OPERAND_WIDTH;
    localparam int CNT_WIDTH  = $clog2(MAG_WIDTH + 1);

    // operation codes
    typedef enum logic [FUNC_WIDTH-1:0] {
        FN_ADD,
        FN_SUB,
        FN_MUL,
        FN_DIV,
        FN_CMP
    } t_func;

    // compare outcome codes
    typedef enum logic [ORDER_WIDTH-1:0] {
        ORD_LESS,
        ORD_EQUAL,
        ORD_GREATER
    } t_order;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_FORM,
        ST_SIGN,
        ST_GCD_TWO,
        ST_GCD,
        ST_DIV_NUM,
        ST_DIV_DEN,
        ST_DONE
    } t_state;

endpackage

// ===== hdl/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Adds, subtracts, multiplies, divides or compares two fractions and returns
// the result reduced by its greatest common divisor.
//
// Usage: a transaction is taken at a rising edge with start high and busy
// low; i_func selects the operation, i_a_* and i_b_* give the operands (a
// zero denominator counts as one). busy stays high until the result is out.
// The result appears on o_res_num, o_res_den, o_order and o_div_zero for
// exactly one cycle, marked by o_valid; the receiver cannot stall it, and a
// new transaction may be started in that same cycle.
// Sequence: the cross products on one shared multiplier, then the fraction is
// formed and signed, then binary gcd on one shared subtractor (one shift or
// subtract per cycle) and two restoring divisions, of the numerator and the
// denominator magnitude by the gcd, on the same subtractor, and then the
// result is presented. Results with a zero numerator (compare, divide by
// zero, unused codes) skip gcd and division.
// One transaction at a time; a new one is accepted only while busy is low.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// o_valid; no result is in flight afterwards.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [FUNC_WIDTH-1:0]           i_func,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_num,
    input  logic [DEN_WIDTH-1:0]            i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_num,
    input  logic [DEN_WIDTH-1:0]            i_b_den,
    output logic                            o_valid,
    output logic signed [RES_NUM_WIDTH-1:0] o_res_num,
    output logic [RES_DEN_WIDTH-1:0]        o_res_den,
    output logic [ORDER_WIDTH-1:0]          o_order,
    output logic                            o_div_zero
);

    // sequencer state
    t_state r_state, n_state;

    // captured operands
    logic [FUNC_WIDTH-1:0]           r_func, n_func;
    logic signed [OPERAND_WIDTH-1:0] r_an, n_an, r_bn, n_bn;
    logic [DEN_WIDTH-1:0]            r_ad, n_ad, r_bd, n_bd;

    // cross products
    logic [1:0]                      r_step, n_step;
    logic signed [PROD_WIDTH-1:0]    r_p_ab, n_p_ab, r_p_ba, n_p_ba;
    logic signed [PROD_WIDTH-1:0]    r_p_nn, n_p_nn, r_p_dd, n_p_dd;

    // unreduced fraction and flags
    logic signed [PROD_WIDTH-1:0]    r_num, n_num, r_den, n_den;
    t_order                          r_ord, n_ord;
    logic                            r_dz, n_dz;

    // magnitudes, gcd and division registers
    logic                            r_neg, n_neg;
    logic [MAG_WIDTH-1:0]            r_mag, n_mag, r_dmag, n_dmag;
    logic [MAG_WIDTH-1:0]            r_u, n_u, r_v, n_v, r_g, n_g;
    logic [CNT_WIDTH-1:0]            r_k, n_k, r_cnt, n_cnt;
    logic [MAG_WIDTH-1:0]            r_rem, n_rem, r_quo, n_quo;

    // output registers
    logic                            r_valid, n_valid;
    logic signed [RES_NUM_WIDTH-1:0] r_res_num, n_res_num;
    logic [RES_DEN_WIDTH-1:0]        r_res_den, n_res_den;
    logic [ORDER_WIDTH-1:0]          r_order, n_order;
    logic                            r_div_zero, n_div_zero;

    // shared multiplier
    logic signed [OPERAND_WIDTH:0]   mul_x, mul_y;
    logic signed [PROD_WIDTH-1:0]    mul_p;

    // shared subtractor
    logic [MAG_WIDTH:0]              sub_a, sub_b, sub_d;

    // helpers
    logic                            accept;
    logic signed [PROD_WIDTH-1:0]    as_sum, abs_num, abs_den;
    logic [MAG_WIDTH:0]              trial;
    logic                            div_ge, div_last, gcd_done, num_zero;
    logic [MAG_WIDTH-1:0]            quo_next;
    logic signed [MAG_WIDTH:0]       signed_mag;

    assign accept = start && (r_state == ST_IDLE);

    // multiplier operand select: an*bd, ad*bn, an*bn, ad*bd
    always_comb begin
        case (r_step)
            2'd0: begin
                mul_x = {r_an[OPERAND_WIDTH-1], r_an};
                mul_y = signed'({2'b00, r_bd});
            end
            2'd1: begin
                mul_x = signed'({2'b00, r_ad});
                mul_y = {r_bn[OPERAND_WIDTH-1], r_bn};
            end
            2'd2: begin
                mul_x = {r_an[OPERAND_WIDTH-1], r_an};
                mul_y = {r_bn[OPERAND_WIDTH-1], r_bn};
            end
            default: begin
                mul_x = signed'({2'b00, r_ad});
                mul_y = signed'({2'b00, r_bd});
            end
        endcase
    end

    assign mul_p = mul_x * mul_y;

    // subtractor operand select: u - v in gcd, trial - g in division
    assign trial = {r_rem, r_quo[MAG_WIDTH-1]};

    always_comb begin
        if (r_state == ST_DIV_NUM || r_state == ST_DIV_DEN) begin
            sub_a = trial;
            sub_b = {1'b0, r_g};
        end else begin
            sub_a = {1'b0, r_u};
            sub_b = {1'b0, r_v};
        end
    end

    assign sub_d = sub_a - sub_b;

    // division step results
    assign div_ge   = !sub_d[MAG_WIDTH];
    assign quo_next = {r_quo[MAG_WIDTH-2:0], div_ge};
    assign div_last = (r_cnt == CNT_WIDTH'(MAG_WIDTH - 1));

    // gcd ends when both values are odd and equal
    assign gcd_done = r_u[0] && r_v[0] && (sub_d == '0);

    // add or subtract of the cross products, also used for compare
    assign as_sum = (r_func == FN_SUB || r_func == FN_CMP) ? (r_p_ab - r_p_ba)
                                                           : (r_p_ab + r_p_ba);

    // magnitudes of the unreduced fraction
    assign abs_num  = r_num[PROD_WIDTH-1] ? -r_num : r_num;
    assign abs_den  = r_den[PROD_WIDTH-1] ? -r_den : r_den;
    assign num_zero = (r_num == '0);

    // signed reduced numerator
    assign signed_mag = r_neg ? -signed'({1'b0, r_mag}) : signed'({1'b0, r_mag});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_MUL;
            end
            ST_MUL: begin
                if (r_step == 2'd3) n_state = ST_FORM;
            end
            ST_FORM: begin
                n_state = ST_SIGN;
            end
            ST_SIGN: begin
                n_state = num_zero ? ST_DONE : ST_GCD_TWO;
            end
            ST_GCD_TWO: begin
                if (r_u[0] || r_v[0]) n_state = ST_GCD;
            end
            ST_GCD: begin
                if (gcd_done) n_state = ST_DIV_NUM;
            end
            ST_DIV_NUM: begin
                if (div_last) n_state = ST_DIV_DEN;
            end
            ST_DIV_DEN: begin
                if (div_last) n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // handshake outputs
    always_comb begin
        busy = (r_state != ST_IDLE);
    end

    // datapath next values
    always_comb begin
        n_func     = r_func;
        n_an       = r_an;
        n_ad       = r_ad;
        n_bn       = r_bn;
        n_bd       = r_bd;
        n_step     = r_step;
        n_p_ab     = r_p_ab;
        n_p_ba     = r_p_ba;
        n_p_nn     = r_p_nn;
        n_p_dd     = r_p_dd;
        n_num      = r_num;
        n_den      = r_den;
        n_ord      = r_ord;
        n_dz       = r_dz;
        n_neg      = r_neg;
        n_mag      = r_mag;
        n_dmag     = r_dmag;
        n_u        = r_u;
        n_v        = r_v;
        n_g        = r_g;
        n_k        = r_k;
        n_cnt      = r_cnt;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_valid    = 1'b0;
        n_res_num  = r_res_num;
        n_res_den  = r_res_den;
        n_order    = r_order;
        n_div_zero = r_div_zero;

        case (r_state)
            // capture a transaction, zero denominators read as one
            ST_IDLE: begin
                if (accept) begin
                    n_func = i_func;
                    n_an   = i_a_num;
                    n_bn   = i_b_num;
                    n_ad   = (i_a_den == '0) ? DEN_WIDTH'(1) : i_a_den;
                    n_bd   = (i_b_den == '0) ? DEN_WIDTH'(1) : i_b_den;
                    n_step = 2'd0;
                end
            end

            // one cross product per cycle
            ST_MUL: begin
                n_step = r_step + 2'd1;
                case (r_step)
                    2'd0:    n_p_ab = mul_p;
                    2'd1:    n_p_ba = mul_p;
                    2'd2:    n_p_nn = mul_p;
                    default: n_p_dd = mul_p;
                endcase
            end

            // pick numerator and denominator for the operation
            ST_FORM: begin
                n_num = '0;
                n_den = PROD_WIDTH'(1);
                n_ord = ORD_EQUAL;
                n_dz  = 1'b0;
                case (r_func)
                    FN_ADD, FN_SUB: begin
                        n_num = as_sum;
                        n_den = r_p_dd;
                    end
                    FN_MUL: begin
                        n_num = r_p_nn;
                        n_den = r_p_dd;
                    end
                    FN_DIV: begin
                        if (r_bn == '0) begin
                            n_dz = 1'b1;
                        end else begin
                            n_num = r_p_ab;
                            n_den = r_p_ba;
                        end
                    end
                    FN_CMP: begin
                        if (as_sum[PROD_WIDTH-1]) begin
                            n_ord = ORD_LESS;
                        end else if (as_sum == '0) begin
                            n_ord = ORD_EQUAL;
                        end else begin
                            n_ord = ORD_GREATER;
                        end
                    end
                    default: begin
                        n_num = '0;
                    end
                endcase
            end

            // move the sign onto the numerator, split into magnitudes
            ST_SIGN: begin
                if (num_zero) begin
                    n_neg  = 1'b0;
                    n_mag  = '0;
                    n_dmag = MAG_WIDTH'(1);
                end else begin
                    n_neg  = r_num[PROD_WIDTH-1] ^ r_den[PROD_WIDTH-1];
                    n_mag  = abs_num[MAG_WIDTH-1:0];
                    n_dmag = abs_den[MAG_WIDTH-1:0];
                    n_u    = abs_num[MAG_WIDTH-1:0];
                    n_v    = abs_den[MAG_WIDTH-1:0];
                    n_k    = '0;
                end
            end

            // strip common factors of two
            ST_GCD_TWO: begin
                if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + CNT_WIDTH'(1);
                end
            end

            // binary gcd: one shift or subtract per cycle
            ST_GCD: begin
                if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (gcd_done) begin
                    n_g   = r_u << r_k;
                    n_rem = '0;
                    n_quo = r_mag;
                    n_cnt = '0;
                end else if (!sub_d[MAG_WIDTH]) begin
                    n_u = sub_d[MAG_WIDTH-1:0];
                end else begin
                    n_v = MAG_WIDTH'(-sub_d);
                end
            end

            // restoring division of the numerator magnitude by the gcd
            ST_DIV_NUM: begin
                n_rem = div_ge ? sub_d[MAG_WIDTH-1:0] : trial[MAG_WIDTH-1:0];
                n_quo = quo_next;
                n_cnt = r_cnt + CNT_WIDTH'(1);
                if (div_last) begin
                    n_mag = quo_next;
                    n_rem = '0;
                    n_quo = r_dmag;
                    n_cnt = '0;
                end
            end

            // restoring division of the denominator by the gcd
            ST_DIV_DEN: begin
                n_rem = div_ge ? sub_d[MAG_WIDTH-1:0] : trial[MAG_WIDTH-1:0];
                n_quo = quo_next;
                n_cnt = r_cnt + CNT_WIDTH'(1);
                if (div_last) begin
                    n_dmag = quo_next;
                end
            end

            // present the result for one cycle
            ST_DONE: begin
                n_valid    = 1'b1;
                n_res_num  = RES_NUM_WIDTH'(signed_mag);
                n_res_den  = RES_DEN_WIDTH'(r_dmag);
                n_order    = r_ord;
                n_div_zero = r_dz;
            end

            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_an       <= n_an;
        r_ad       <= n_ad;
        r_bn       <= n_bn;
        r_bd       <= n_bd;
        r_step     <= n_step;
        r_p_ab     <= n_p_ab;
        r_p_ba     <= n_p_ba;
        r_p_nn     <= n_p_nn;
        r_p_dd     <= n_p_dd;
        r_num      <= n_num;
        r_den      <= n_den;
        r_ord      <= n_ord;
        r_dz       <= n_dz;
        r_neg      <= n_neg;
        r_mag      <= n_mag;
        r_dmag     <= n_dmag;
        r_u        <= n_u;
        r_v        <= n_v;
        r_g        <= n_g;
        r_k        <= n_k;
        r_cnt      <= n_cnt;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_res_num  <= n_res_num;
        r_res_den  <= n_res_den;
        r_order    <= n_order;
        r_div_zero <= n_div_zero;
    end

    // result ports
    assign o_valid    = r_valid;
    assign o_res_num  = r_res_num;
    assign o_res_den  = r_res_den;
    assign o_order    = r_order;
    assign o_div_zero = r_div_zero;

endmodule
